FILE: sv/crc10fc_pkg.sv
// Shared types and constants for the CRC-10 register frame checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package crc10fc_pkg;

  // Number of device groups in a frame before the index wraps to zero.
  localparam int MAX_DEVICES = 16;
  // Device counter width: at least four bits so the reported index is always a slice.
  localparam int DEV_W = (MAX_DEVICES > 16) ? $clog2(MAX_DEVICES) : 4;
  localparam logic [DEV_W-1:0] DEV_LAST = DEV_W'(MAX_DEVICES - 1);

  // CRC-10 polynomial and seed.
  localparam logic [9:0] CRC_POLY = 10'h08F;
  localparam logic [9:0] CRC_INIT = 10'd16;

  // Largest usable data byte count; the position counter is six bits wide.
  localparam logic [5:0] DB_MAX   = 6'd62;
  localparam logic [5:0] DB_RESET = 6'd6;

  // Which part of a byte enters the CRC.
  typedef enum logic {
    CRC_DATA_BYTE,
    CRC_COUNTER_BITS
  } crc_mode_t;

  // One received byte with its frame start flag.
  typedef struct packed {
    logic       start_frame;
    logic [7:0] rx_byte;
  } rx_item_t;

  // One checked device group.
  typedef struct packed {
    logic       pec_mismatch;
    logic [9:0] computed_pec;
    logic [9:0] received_pec;
    logic [5:0] cmd_count;
    logic [3:0] device_index;
  } pec_result_t;

endpackage

`default_nettype wire

FILE: sv/crc10fc_crc_step.sv
// Unrolled MSB-first CRC-10 update over one byte or over the six counter bits.
// Depends on crc10fc_pkg.
`default_nettype none

module crc10fc_crc_step (
  input  crc10fc_pkg::crc_mode_t mode,
  input  logic [9:0]             rem_in,
  input  logic [7:0]             data,
  output logic [9:0]             rem_out
);
  import crc10fc_pkg::*;

  logic [9:0] x;

  // Fold the incoming bits into the top of the remainder, then shift them out.
  always_comb begin
    if (mode == CRC_DATA_BYTE) begin
      x = rem_in ^ {data, 2'b00};
    end else begin
      x = rem_in ^ {data[7:2], 4'b0000};
    end
    for (int i = 0; i < 8; i++) begin
      if (mode == CRC_DATA_BYTE || i < 6) begin
        if (x[9]) begin
          x = {x[8:0], 1'b0} ^ CRC_POLY;
        end else begin
          x = {x[8:0], 1'b0};
        end
      end
    end
    rem_out = x;
  end

endmodule

`default_nettype wire

FILE: sv/crc10fc_core.sv
// Frame state of the checker: byte position, device counter, CRC remainder
// and held counter byte, updated once per byte. Depends on crc10fc_pkg and
// crc10fc_crc_step.
`default_nettype none

module crc10fc_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_valid,
  input  crc10fc_pkg::rx_item_t    item,
  input  logic [5:0]               data_bytes,
  input  logic                     out_free,
  output logic                     take,
  output logic                     res_valid,
  output crc10fc_pkg::pec_result_t result
);
  import crc10fc_pkg::*;

  logic [9:0]       crc_r, crc_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic [DEV_W-1:0] dev_r, dev_nxt;
  logic [7:0]       held_r, held_nxt;

  logic [9:0]       crc0, crc_step;
  logic [5:0]       pos0, db;
  logic [DEV_W-1:0] dev0;
  logic             is_data, is_counter, is_result;
  logic [9:0]       rx_pec;
  crc_mode_t        mode;

  // A start flag restarts the frame before the byte is handled.
  always_comb begin
    pos0 = item.start_frame ? 6'd0 : pos_r;
    dev0 = item.start_frame ? '0 : dev_r;
    crc0 = item.start_frame ? CRC_INIT : crc_r;
    db   = (data_bytes > DB_MAX) ? DB_MAX : data_bytes;
  end

  // Classify the byte by its place in the group.
  assign is_data    = pos0 < db;
  assign is_counter = pos0 == db;
  assign is_result  = !is_data && !is_counter;
  assign mode       = is_data ? CRC_DATA_BYTE : CRC_COUNTER_BITS;

  crc10fc_crc_step u_crc_step (
    .mode    (mode),
    .rem_in  (crc0),
    .data    (item.rx_byte),
    .rem_out (crc_step)
  );

  // A byte that closes a group waits until the result register can take it.
  assign take      = item_valid && (!is_result || out_free);
  assign res_valid = take && is_result;

  // Result fields of a closed group.
  always_comb begin
    rx_pec              = {held_r[1:0], item.rx_byte};
    result.device_index = dev0[3:0];
    result.cmd_count    = held_r[7:2];
    result.received_pec = rx_pec;
    result.computed_pec = crc0;
    result.pec_mismatch = rx_pec != crc0;
  end

  // Next state for a transferred byte.
  always_comb begin
    crc_nxt  = crc_r;
    pos_nxt  = pos_r;
    dev_nxt  = dev_r;
    held_nxt = held_r;
    if (take) begin
      if (is_result) begin
        crc_nxt = CRC_INIT;
        pos_nxt = 6'd0;
        dev_nxt = (dev0 == DEV_LAST) ? '0 : dev0 + 1'b1;
      end else begin
        crc_nxt = crc_step;
        pos_nxt = pos0 + 6'd1;
        dev_nxt = dev0;
        if (is_counter) begin
          held_nxt = item.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      pos_r  <= 6'd0;
      dev_r  <= '0;
      held_r <= 8'd0;
    end else begin
      crc_r  <= crc_nxt;
      pos_r  <= pos_nxt;
      dev_r  <= dev_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/crc10_register_frame_checker.sv
// Checks the CRC-10 PEC of each device group in a daisy-chain register read,
// one received byte per transfer. in_tuser marks the first byte of a frame. Each group is
// data_bytes data bytes, a counter byte (command counter in bits 7..2, PEC
// bits 9..8 in bits 1..0) and a PEC low byte; one result leaves per group, on
// its PEC low byte. The block takes one byte every cycle while the input does
// not stall. A byte is held in the input register, and its result is shown on
// out_tvalid from the result register; the unrolled eight-bit CRC update lies
// between the input register and the CRC remainder register. Input stalls
// only while a finished result is held on the output and the next byte would
// also close a group. Write cfg_wdata only while no byte is in flight; values
// above 62 act as 62. Depends on crc10fc_pkg, crc10fc_core and crc10fc_crc_step.
`default_nettype none

module crc10_register_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: data bytes per device group.
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  // Received bytes.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] start_frame
  // Group results.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [3:0] device_index, [9:4] cmd_count,
                                  // [19:10] received_pec, [29:20] computed_pec,
                                  // [30] pec_mismatch, [31] zero
);
  import crc10fc_pkg::*;

  logic [5:0]  data_bytes_r, data_bytes_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  rx_item_t    s1_item_r, s1_item_nxt;
  logic        out_valid_r, out_valid_nxt;
  pec_result_t out_res_r, out_res_nxt;

  logic        in_xfer, core_take, res_valid, out_free;
  pec_result_t core_res;

  // Configuration register.
  assign data_bytes_nxt = cfg_we ? cfg_wdata : data_bytes_r;

  // Input register: refilled whenever it is empty or the held byte moves on.
  assign in_tready = !s1_valid_r || core_take;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_item_nxt  = s1_item_r;
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt          = 1'b1;
      s1_item_nxt.start_frame = in_tuser;
      s1_item_nxt.rx_byte   = in_tdata;
    end else if (core_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  assign out_free = !out_valid_r || out_tready;

  crc10fc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .data_bytes (data_bytes_r),
    .out_free   (out_free),
    .take       (core_take),
    .res_valid  (res_valid),
    .result     (core_res)
  );

  // Result register.
  always_comb begin
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = core_res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bytes_r <= DB_RESET;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      data_bytes_r <= data_bytes_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.pec_mismatch, out_res_r.computed_pec,
                       out_res_r.received_pec, out_res_r.cmd_count,
                       out_res_r.device_index};

  // The mismatch flag always agrees with the two PEC fields it compares.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.pec_mismatch ==
                     (out_res_r.received_pec != out_res_r.computed_pec)))
    else $error("pec_mismatch disagrees with the PEC fields");

  // Input stalls only when a held byte is blocked by a full result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  // A new result can only come from a byte held in the input register.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> s1_valid_r)
    else $error("result produced without a held byte");

  // A result register that fills always had a byte waiting in the cycle before.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a source byte");

endmodule

`default_nettype wire
